>>> design/tfilt_pkg.sv
// Package for the text whitespace and case filter.
// Holds flag bit positions, character codes, the result record, the sequencer
// state type and the character helper functions; no dependencies.
package tfilt_pkg;

	localparam int FLAGS_W = 6;

	// Bit positions in the edit flags register
	localparam int FLG_COLLAPSE  = 0;
	localparam int FLG_COMPRESS  = 1;
	localparam int FLG_LOWER     = 2;
	localparam int FLG_TRIM      = 3;
	localparam int FLG_UNCOMMENT = 4;
	localparam int FLG_UPCASE    = 5;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CASE_OFS = 8'd32;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       trim_overflow;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_TAIL
	} state_t;

	function automatic logic is_ws(input logic [7:0] c);
		return c inside {CH_SPACE, [8'h09:8'h0D]};
	endfunction

	function automatic logic [7:0] fold_case(input logic [FLAGS_W-1:0] flags,
		input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (flags[FLG_UPCASE]) begin
			if (c inside {[8'h61:8'h7A]})
				r = c - CASE_OFS;
		end else if (flags[FLG_LOWER]) begin
			if (c inside {[8'h41:8'h5A]})
				r = c + CASE_OFS;
		end
		return r;
	endfunction

endpackage

>>> design/tfilt_in_if.sv
// Input channel of the text filter: one character per transaction.
// Valid/ready handshake; no dependencies.
interface tfilt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

>>> design/tfilt_out_if.sv
// Output channel of the text filter: one edited character per transaction.
// Valid/ready handshake; no dependencies.
interface tfilt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       trim_overflow;

	modport source (output valid, output out_byte, output run_last, output trim_overflow,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input trim_overflow,
		output ready);
endinterface

>>> design/tfilt_pend_ram.sv
// Pending whitespace store: one write port, one read port, registered read.
// Read data holds until the next read; no dependencies.
module tfilt_pend_ram #(
	parameter int DEPTH = 63,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/tfilt_ctl.sv
// Filter control: per-character decision, string state and the flush sequencer
// that drains the pending store. Depends on tfilt_pkg and tfilt_pend_ram ports.
module tfilt_ctl
	import tfilt_pkg::*;
#(
	parameter int MAX_CHARS     = 1023,
	parameter int PENDING_DEPTH = 63,
	parameter int AW            = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [FLAGS_W-1:0] flags,
	input  logic               in_valid,
	input  logic [7:0]         in_byte,
	output logic               in_ready,
	input  logic               load_ok,
	output logic               res_vld,
	output res_t               res,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output logic [7:0]         wr_data,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  logic [7:0]         rd_data
);

	localparam int NW = $clog2(MAX_CHARS + 1);
	localparam int CW = $clog2(PENDING_DEPTH + 1);

	typedef enum logic [2:0] {
		DC_TERM,
		DC_SKIP,
		DC_DROP,
		DC_HOLD,
		DC_FLUSH,
		DC_CUT,
		DC_EMIT
	} dec_t;

	typedef enum logic [1:0] {
		TL_EMIT,
		TL_CUT,
		TL_HOLD
	} tail_t;

	state_t         state_q, state_d;
	logic [NW-1:0]  char_cnt_q;
	logic           at_start_q;
	logic           run_q;
	logic           comment_q;
	logic [CW-1:0]  pend_cnt_q;
	logic [CW-1:0]  rd_ptr_q;
	logic           rd_vld_s1;
	logic           rd_last_s1;
	tail_t          tail_kind_q;
	logic [7:0]     tail_byte_q;
	logic           ovf_q;

	logic           ws;
	logic           compress_on;
	logic           bang;
	logic [7:0]     eff;
	dec_t           dec;
	tail_t          dec_tail;
	logic           dec_ovf;
	logic           in_fire;
	logic           consume;
	logic           flush_done;

	// Classify the offered character against the current string state
	always_comb begin
		ws          = is_ws(in_byte);
		compress_on = !flags[FLG_COLLAPSE] && flags[FLG_COMPRESS];
		eff         = (compress_on && ws) ? CH_SPACE : in_byte;
		bang        = flags[FLG_UNCOMMENT] && (eff == CH_BANG);
		dec         = DC_SKIP;
		dec_tail    = TL_EMIT;
		dec_ovf     = 1'b0;
		if (in_byte == CH_NUL) begin
			dec = DC_TERM;
		end else if (comment_q || (char_cnt_q == NW'(MAX_CHARS))) begin
			dec = DC_SKIP;
		end else if (ws && (flags[FLG_COLLAPSE] || (compress_on && run_q))) begin
			dec = DC_DROP;
		end else if (ws && flags[FLG_TRIM]) begin
			if (at_start_q && (eff != CH_TAB)) begin
				dec = DC_DROP;
			end else if (pend_cnt_q == CW'(PENDING_DEPTH)) begin
				dec      = DC_FLUSH;
				dec_tail = TL_HOLD;
				dec_ovf  = 1'b1;
			end else begin
				dec = DC_HOLD;
			end
		end else if (pend_cnt_q != '0) begin
			dec      = DC_FLUSH;
			dec_tail = bang ? TL_CUT : TL_EMIT;
		end else if (bang) begin
			dec = DC_CUT;
		end else begin
			dec = DC_EMIT;
		end
	end

	assign in_fire    = in_valid && in_ready;
	assign consume    = (state_q == ST_FLUSH) && rd_vld_s1 && load_ok;
	assign flush_done = consume && rd_last_s1;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && (dec == DC_FLUSH))
					state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (flush_done)
					state_d = ST_TAIL;
			end
			ST_TAIL: begin
				if ((tail_kind_q != TL_EMIT) || load_ok)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshake, result, store accesses
	always_comb begin
		in_ready = 1'b0;
		res_vld  = 1'b0;
		res      = '{out_byte: CH_NUL, run_last: 1'b0, trim_overflow: 1'b0};
		wr_en    = 1'b0;
		wr_addr  = pend_cnt_q[AW-1:0];
		wr_data  = eff;
		rd_en    = 1'b0;
		rd_addr  = rd_ptr_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				in_ready = load_ok;
				if (in_fire) begin
					if (dec == DC_TERM) begin
						res_vld = 1'b1;
						res     = '{out_byte: CH_NUL, run_last: 1'b1, trim_overflow: 1'b0};
					end else if (dec == DC_EMIT) begin
						res_vld = 1'b1;
						res     = '{out_byte: fold_case(flags, eff), run_last: 1'b1,
							trim_overflow: 1'b0};
					end
					wr_en = (dec == DC_HOLD);
				end
			end
			ST_FLUSH: begin
				rd_en = (rd_ptr_q != pend_cnt_q) && (!rd_vld_s1 || consume);
				if (consume) begin
					res_vld = 1'b1;
					res     = '{out_byte: rd_data,
						run_last: rd_last_s1 && (tail_kind_q != TL_EMIT),
						trim_overflow: ovf_q};
				end
			end
			ST_TAIL: begin
				if (tail_kind_q == TL_EMIT) begin
					res_vld = load_ok;
					res     = '{out_byte: tail_byte_q, run_last: 1'b1, trim_overflow: 1'b0};
				end else if (tail_kind_q == TL_HOLD) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = tail_byte_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			char_cnt_q  <= '0;
			at_start_q  <= 1'b1;
			run_q       <= 1'b0;
			comment_q   <= 1'b0;
			pend_cnt_q  <= '0;
			rd_ptr_q    <= '0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			tail_kind_q <= TL_EMIT;
			ovf_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				if (dec == DC_TERM) begin
					char_cnt_q <= '0;
					at_start_q <= 1'b1;
					run_q      <= 1'b0;
					comment_q  <= 1'b0;
					pend_cnt_q <= '0;
				end else if (dec != DC_SKIP) begin
					char_cnt_q <= char_cnt_q + NW'(1);
					if (compress_on)
						run_q <= ws;
					if (dec != DC_DROP)
						at_start_q <= 1'b0;
					if ((dec == DC_CUT) || ((dec == DC_FLUSH) && (dec_tail == TL_CUT)))
						comment_q <= 1'b1;
					if (dec == DC_HOLD)
						pend_cnt_q <= pend_cnt_q + CW'(1);
					if (dec == DC_FLUSH) begin
						tail_kind_q <= dec_tail;
						ovf_q       <= dec_ovf;
						rd_ptr_q    <= '0;
					end
				end
			end
			// Advance the read pointer and track the registered read data
			if (rd_en) begin
				rd_ptr_q   <= rd_ptr_q + CW'(1);
				rd_last_s1 <= (rd_ptr_q + CW'(1)) == pend_cnt_q;
			end
			if (rd_en)
				rd_vld_s1 <= 1'b1;
			else if (consume)
				rd_vld_s1 <= 1'b0;
			// Store drained: leave one entry when the new whitespace is held
			if ((state_q == ST_TAIL) && (state_d == ST_IDLE))
				pend_cnt_q <= (tail_kind_q == TL_HOLD) ? CW'(1) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && (dec == DC_FLUSH))
			tail_byte_q <= (dec_tail == TL_HOLD) ? eff : fold_case(flags, eff);
	end

	a_no_write_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> !wr_en)
		else $error("pending store written during flush");

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (pend_cnt_q != '0))
		else $error("flush entered with empty pending store");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q <= CW'(PENDING_DEPTH))
		else $error("pending count beyond store depth");

	a_res_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |-> load_ok)
		else $error("result produced without a free output slot");

	a_rd_only_flush: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_FLUSH))
		else $error("read data pending outside flush");

endmodule

>>> design/text_whitespace_case_filter_unit.sv
// Top level of the text whitespace and case filter: edit flags register,
// output register, control and pending store. Depends on tfilt_pkg,
// tfilt_in_if, tfilt_out_if, tfilt_pend_ram and tfilt_ctl.
//
//  channel   | dir | transaction payload
//  ----------+-----+--------------------------------------------------
//  in_ch     | in  | in_byte: next character, zero ends the string
//  out_ch    | out | out_byte, run_last, trim_overflow
//  cfg       | in  | cfg_we / cfg_wdata: edit flags, written at once
//
// After an input character that releases no held whitespace, the
// next one is accepted in the following cycle whenever the output register
// is free or being drained.
// A character that flushes N held whitespace entries is handled in order:
// it is accepted, the pending store is read through its registered read port,
// one read is made per output transaction, and a closing step emits the
// character, cuts at a comment mark or holds the new whitespace.
// Output stalls hold the flush in place; the store read data waits in its
// register until the output register can take it.
// Reset is asynchronous and active low; it clears the flags and all string
// state. The pending store itself is not cleared: only entries below the
// pending count are ever read.
module text_whitespace_case_filter_unit
	import tfilt_pkg::*;
#(
	parameter int MAX_CHARS     = 1023,
	parameter int PENDING_DEPTH = 63
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [FLAGS_W-1:0] cfg_wdata,
	tfilt_in_if.sink           in_ch,
	tfilt_out_if.source        out_ch
);

	localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

	logic [FLAGS_W-1:0] flags_q;
	logic               out_vld_q;
	res_t               out_res_q;
	logic               load_ok;
	logic               res_vld;
	res_t               res;
	logic               in_rdy;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [7:0]         wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [7:0]         rd_data;

	// Edit flags: to be written only while the filter is idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			flags_q <= '0;
		else if (cfg_we)
			flags_q <= cfg_wdata;
	end

	// Output register: load a new result whenever it is empty or being taken
	assign load_ok = !out_vld_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (res_vld)
			out_vld_q <= 1'b1;
		else if (out_ch.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_vld)
			out_res_q <= res;
	end

	assign out_ch.valid         = out_vld_q;
	assign out_ch.out_byte      = out_res_q.out_byte;
	assign out_ch.run_last      = out_res_q.run_last;
	assign out_ch.trim_overflow = out_res_q.trim_overflow;
	assign in_ch.ready          = in_rdy;

	tfilt_ctl #(
		.MAX_CHARS     (MAX_CHARS),
		.PENDING_DEPTH (PENDING_DEPTH),
		.AW            (AW)
	) u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.flags    (flags_q),
		.in_valid (in_ch.valid),
		.in_byte  (in_ch.in_byte),
		.in_ready (in_rdy),
		.load_ok  (load_ok),
		.res_vld  (res_vld),
		.res      (res),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	tfilt_pend_ram #(
		.DEPTH (PENDING_DEPTH),
		.AW    (AW)
	) u_pend_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ch.ready) |-> !res_vld)
		else $error("result overwrote a stalled output");

	a_in_blocked_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ch.ready) |-> !in_rdy)
		else $error("input accepted while output slot is blocked");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !out_vld_q)
		else $error("edit flags written while a result is pending");

endmodule
